// ----- sv/cert_record_parser_assert.svh -----
// Assertion macros used by the checker file.
`ifndef CERT_RECORD_PARSER_ASSERT_SVH
`define CERT_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/crp_pkg.sv -----
`default_nettype none

package crp_pkg;

    // Record layout (byte positions from the start of the record)
    localparam int TAG_LEN     = 12;
    localparam int VER_POS     = 10;
    localparam int ALGO_POS    = 12;
    localparam int FLAGS_POS   = 13;
    localparam int TIME_BASE   = 14;
    localparam int MASK_BASE   = 70;
    localparam int SIG_BASE_V1 = 70;
    localparam int SIG_BASE_V2 = 78;
    localparam int SIG_LEN     = 64;
    localparam int LEN_V1      = 134;
    localparam int LEN_V2      = 142;
    localparam int POS_MAX     = 255;

    localparam int NUM_WORDS   = 16;

    // Version codes
    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_1    = 2'd1;
    localparam logic [1:0] VER_2    = 2'd2;

    // Version digit bytes in the tag
    localparam logic [7:0] DIGIT_V1 = 8'h31;
    localparam logic [7:0] DIGIT_V2 = 8'h32;

    localparam logic [7:0] ALGO_SUPPORTED = 8'h01;

    // Word kinds
    localparam logic [3:0] KIND_MASK = 4'd7;
    localparam logic [3:0] KIND_LAST = 4'd15;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_BAD_ALGO   = 2'd3
    } status_t;

    typedef logic [NUM_WORDS-1:0][63:0] words_t;

    // Verdict handed from the capture stage to the emitter
    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [1:0] version;
        logic [7:0] algo;
        logic [7:0] flags;
    } launch_t;

    // Expected tag byte; the version digit slot is checked apart
    function automatic logic [7:0] tag_byte(input logic [3:0] idx);
        logic [7:0] val;
        unique case (idx)
            4'd0:    val = 8'h4F;
            4'd1:    val = 8'h52;
            4'd2:    val = 8'h45;
            4'd3:    val = 8'h4E;
            4'd4:    val = 8'h5F;
            4'd5:    val = 8'h43;
            4'd6:    val = 8'h45;
            4'd7:    val = 8'h52;
            4'd8:    val = 8'h54;
            4'd9:    val = 8'h0A;
            4'd11:   val = 8'h0A;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- sv/crp_if.sv -----
`default_nettype none

// Byte channel into the parser
interface crp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_record;

    modport source (output valid, output byte_value, output end_of_record, input ready);
    modport sink   (input valid, input byte_value, input end_of_record, output ready);
endinterface

// Result channel out of the parser
interface crp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  cert_version;
    logic [7:0]  algo_code;
    logic [7:0]  flag_bits;
    logic [3:0]  word_kind;
    logic [63:0] word_value;
    logic        last_word;

    modport source (output valid, output status, output cert_version, output algo_code,
                    output flag_bits, output word_kind, output word_value,
                    output last_word, input ready);
    modport sink   (input valid, input status, input cert_version, input algo_code,
                    input flag_bits, input word_kind, input word_value,
                    input last_word, output ready);
endinterface

`default_nettype wire

// ----- sv/crp_capture.sv -----
`default_nettype none

module crp_capture (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire logic [7:0]       byte_value,
    input  wire logic             end_of_record,
    input  wire logic             emit_free,
    output crp_pkg::launch_t      launch,
    output crp_pkg::words_t       words
);

    // Input register
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_eor_reg;
    logic       stg_adv;

    // Record state
    logic [7:0]      pos_reg, pos_next;
    logic [1:0]      prefix_reg, prefix_next;
    logic            bad_reg, bad_next;
    logic [7:0]      algo_reg, algo_next;
    logic [7:0]      flags_reg, flags_next;
    crp_pkg::words_t words_reg, words_next;

    // Byte steering
    logic       wr_en;
    logic [3:0] wr_kind;
    logic [2:0] wr_lane;
    logic [7:0] sig_base;
    logic [7:0] off_time;
    logic [7:0] off_mask;
    logic [7:0] off_sig;

    // Verdict
    logic [8:0] rec_len;
    logic [8:0] need_len;
    logic       too_short;

    // Final byte waits until the emitter can take the whole record
    assign stg_adv    = stg_valid_reg && (!stg_eor_reg || emit_free);
    assign item_ready = !stg_valid_reg || stg_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (stg_adv)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stg_byte_reg <= byte_value;
            stg_eor_reg  <= end_of_record;
        end
    end

    // Decode the position: tag check, header capture, word byte lane
    always_comb
    begin
        prefix_next = prefix_reg;
        bad_next    = bad_reg;
        algo_next   = algo_reg;
        flags_next  = flags_reg;
        wr_en       = 1'b0;
        wr_kind     = '0;
        wr_lane     = '0;
        sig_base    = (prefix_reg == crp_pkg::VER_2) ? 8'(crp_pkg::SIG_BASE_V2)
                                                     : 8'(crp_pkg::SIG_BASE_V1);
        off_time    = pos_reg - 8'(crp_pkg::TIME_BASE);
        off_mask    = pos_reg - 8'(crp_pkg::MASK_BASE);
        off_sig     = pos_reg - sig_base;

        priority if (pos_reg < 8'(crp_pkg::TAG_LEN))
        begin
            if (pos_reg == 8'(crp_pkg::VER_POS))
            begin
                priority if (stg_byte_reg == crp_pkg::DIGIT_V1)
                    prefix_next = crp_pkg::VER_1;
                else if (stg_byte_reg == crp_pkg::DIGIT_V2)
                    prefix_next = crp_pkg::VER_2;
                else
                    bad_next = 1'b1;
            end
            else if (stg_byte_reg != crp_pkg::tag_byte(pos_reg[3:0]))
            begin
                bad_next = 1'b1;
            end
        end
        else if (pos_reg == 8'(crp_pkg::ALGO_POS))
        begin
            algo_next = stg_byte_reg;
        end
        else if (pos_reg == 8'(crp_pkg::FLAGS_POS))
        begin
            flags_next = stg_byte_reg;
        end
        else if (pos_reg < 8'(crp_pkg::MASK_BASE))
        begin
            // times, subject key and key id: kinds 0..6
            wr_en   = 1'b1;
            wr_kind = {1'b0, off_time[5:3]};
            wr_lane = off_time[2:0];
        end
        else if (prefix_reg == crp_pkg::VER_2 && pos_reg < 8'(crp_pkg::SIG_BASE_V2))
        begin
            wr_en   = 1'b1;
            wr_kind = crp_pkg::KIND_MASK;
            wr_lane = off_mask[2:0];
        end
        else if (pos_reg >= sig_base && pos_reg < sig_base + 8'(crp_pkg::SIG_LEN))
        begin
            wr_en   = 1'b1;
            wr_kind = {1'b1, off_sig[5:3]};
            wr_lane = off_sig[2:0];
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    // Word store with this byte merged in
    always_comb
    begin
        for (int k = 0; k < crp_pkg::NUM_WORDS; k++)
        begin
            words_next[k] = words_reg[k];
            if (wr_en && wr_kind == 4'(k))
            begin
                words_next[k][{wr_lane, 3'b000} +: 8] = stg_byte_reg;
            end
        end
    end

    // Saturating position
    assign pos_next = (pos_reg < 8'(crp_pkg::POS_MAX)) ? pos_reg + 8'd1 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            prefix_reg <= crp_pkg::VER_NONE;
            bad_reg    <= 1'b0;
            algo_reg   <= '0;
            flags_reg  <= '0;
        end
        else if (stg_adv)
        begin
            if (stg_eor_reg)
            begin
                pos_reg    <= '0;
                prefix_reg <= crp_pkg::VER_NONE;
                bad_reg    <= 1'b0;
                algo_reg   <= '0;
                flags_reg  <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                prefix_reg <= prefix_next;
                bad_reg    <= bad_next;
                algo_reg   <= algo_next;
                flags_reg  <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_adv)
        begin
            words_reg <= words_next;
        end
    end

    // Judge the record on its final byte: prefix, then length, then algo
    assign rec_len   = {1'b0, pos_reg} + 9'd1;
    assign need_len  = (prefix_next == crp_pkg::VER_1) ? 9'(crp_pkg::LEN_V1)
                                                       : 9'(crp_pkg::LEN_V2);
    assign too_short = rec_len < 9'(crp_pkg::TAG_LEN);

    always_comb
    begin
        launch.valid   = stg_adv && stg_eor_reg;
        launch.status  = crp_pkg::ST_OK;
        launch.version = prefix_next;
        launch.algo    = algo_next;
        launch.flags   = flags_next;
        priority if (too_short || bad_next || prefix_next == crp_pkg::VER_NONE)
        begin
            launch.status  = crp_pkg::ST_BAD_PREFIX;
            launch.version = crp_pkg::VER_NONE;
            launch.algo    = '0;
            launch.flags   = '0;
        end
        else if (rec_len != need_len)
        begin
            launch.status = crp_pkg::ST_BAD_LENGTH;
        end
        else if (algo_next != crp_pkg::ALGO_SUPPORTED)
        begin
            launch.status = crp_pkg::ST_BAD_ALGO;
        end
        else
        begin
            launch.status = crp_pkg::ST_OK;
        end
    end

    // Domain mask reads as zero unless the record is version 2
    always_comb
    begin
        words = words_next;
        if (prefix_next != crp_pkg::VER_2)
        begin
            words[crp_pkg::KIND_MASK] = '0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/crp_emit.sv -----
`default_nettype none

module crp_emit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire crp_pkg::launch_t launch,
    input  wire crp_pkg::words_t  words,
    output logic                  emit_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            status,
    output logic [1:0]            cert_version,
    output logic [7:0]            algo_code,
    output logic [7:0]            flag_bits,
    output logic [3:0]            word_kind,
    output logic [63:0]           word_value,
    output logic                  last_word
);

    logic            busy_reg;
    logic [3:0]      idx_reg;
    logic            err_reg;
    logic [1:0]      status_reg;
    logic [1:0]      ver_reg;
    logic [7:0]      algo_reg;
    logic [7:0]      flags_reg;
    crp_pkg::words_t buf_reg;
    logic            is_last;
    logic            take;

    assign is_last   = err_reg || (idx_reg == crp_pkg::KIND_LAST);
    assign take      = busy_reg && out_ready;
    assign emit_free = !busy_reg || (out_ready && is_last);

    // Sequencer over the buffered words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else if (launch.valid)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            err_reg  <= (launch.status != crp_pkg::ST_OK);
        end
        else if (take)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    // Snapshot of the record, free for the next one to overwrite the store
    always_ff @(posedge clk)
    begin
        if (launch.valid)
        begin
            status_reg <= launch.status;
            ver_reg    <= launch.version;
            algo_reg   <= launch.algo;
            flags_reg  <= launch.flags;
            buf_reg    <= words;
        end
    end

    // Result fields
    always_comb
    begin
        out_valid    = busy_reg;
        status       = status_reg;
        cert_version = ver_reg;
        algo_code    = algo_reg;
        flag_bits    = flags_reg;
        word_kind    = err_reg ? 4'd0 : idx_reg;
        word_value   = err_reg ? 64'd0 : buf_reg[idx_reg];
        last_word    = is_last;
    end

endmodule

`default_nettype wire

// ----- sv/cert_record_parser.sv -----
`default_nettype none

// Certificate record parser. Takes one record byte per item on rec_bytes, the
// final byte flagged by end_of_record, and on that byte gives either a single
// error item (status 1..3, last_word set) or 16 word items with status 0,
// word_kind 0..15 in order. Bytes are taken one per cycle unless a final byte
// waits: the final byte of a record is held in the input register until the
// result buffer is free, then passes into it ahead of the first result, so a
// record that closes while the previous one still drains waits until that
// one's last word item is taken on results. The 16 result words are
// snapshotted into a buffer, so the next record streams in while they drain.
module cert_record_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    crp_in_if.sink     rec_bytes,
    crp_out_if.source  results
);

    crp_pkg::launch_t launch;
    crp_pkg::words_t  words;
    logic             emit_free;

    crp_capture u_capture (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (rec_bytes.valid),
        .item_ready    (rec_bytes.ready),
        .byte_value    (rec_bytes.byte_value),
        .end_of_record (rec_bytes.end_of_record),
        .emit_free     (emit_free),
        .launch        (launch),
        .words         (words)
    );

    crp_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .launch       (launch),
        .words        (words),
        .emit_free    (emit_free),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .status       (results.status),
        .cert_version (results.cert_version),
        .algo_code    (results.algo_code),
        .flag_bits    (results.flag_bits),
        .word_kind    (results.word_kind),
        .word_value   (results.word_value),
        .last_word    (results.last_word)
    );

endmodule

`default_nettype wire

// ----- sv/crp_checker.sv -----
`default_nettype none

`include "cert_record_parser_assert.svh"

module crp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [1:0]  cert_version,
    input wire logic [7:0]  algo_code,
    input wire logic [3:0]  word_kind,
    input wire logic [63:0] word_value,
    input wire logic        last_word
);

    // A stalled result stays offered
    `CRP_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // Error items are single, empty and final
    `CRP_ASSERT_NOW(a_err_item, out_valid && status != 2'd0, last_word && word_kind == 4'd0 && word_value == 64'd0, "malformed error item")

    // A good record ends on the last signature word
    `CRP_ASSERT_NOW(a_ok_last, out_valid && status == 2'd0 && last_word, word_kind == 4'd15, "good record ended early")

    // Good records carry a version and the supported algo
    `CRP_ASSERT_NOW(a_ok_hdr, out_valid && status == 2'd0, (cert_version == 2'd1 || cert_version == 2'd2) && algo_code == 8'd1, "bad header on good record")

    // Word items of one record follow without gaps, kinds counting up
    `CRP_ASSERT_NEXT(a_seq, out_valid && out_ready && !last_word, out_valid && word_kind == $past(word_kind) + 4'd1, "word sequence broken")

endmodule

bind cert_record_parser crp_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .status       (results.status),
    .cert_version (results.cert_version),
    .algo_code    (results.algo_code),
    .word_kind    (results.word_kind),
    .word_value   (results.word_value),
    .last_word    (results.last_word)
);

`default_nettype wire
